// ===== rtl/crcdec_pkg.sv =====
// ----------------------------------------------------------------------------
// crcdec_pkg
// Shared types and constants for the card record CRC check and field decoder.
// ----------------------------------------------------------------------------
package crcdec_pkg;

    // Record layout.
    localparam int RECORD_BYTES_DEF = 48;
    localparam int CRC_POS          = 29;
    localparam int MIN_BYTES        = 30;
    localparam int STORE_DEPTH      = 28;
    localparam int ADDR_W           = $clog2(STORE_DEPTH);

    // CRC-8 polynomial and initial value.
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    // Configuration register indexes.
    localparam int                CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'd1;

    // Emit sequence steps.
    localparam int                STEP_W       = 6;
    localparam logic [STEP_W-1:0] STEP_STATUS  = 6'd0;
    localparam logic [STEP_W-1:0] STEP_DIGIT_L = 6'd10;
    localparam logic [STEP_W-1:0] STEP_ID_LO   = 6'd11;
    localparam logic [STEP_W-1:0] STEP_ID_HI   = 6'd12;
    localparam logic [STEP_W-1:0] STEP_LAST    = 6'd32;
    localparam logic [STEP_W-1:0] NAME_OFFSET  = 6'd5;

    // ASCII zero added to each phone digit nibble.
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CRC,
        S_READ,
        S_WRITE
    } t_state;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_DIGIT  = 2'd1,
        KIND_ID     = 2'd2,
        KIND_NAME   = 2'd3
    } t_kind;

    // Status codes; the header error codes share the low values.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_MAGIC   = 3'd1,
        ST_VERSION = 3'd2,
        ST_CRC     = 3'd3,
        ST_SHORT   = 3'd4
    } t_status;

    // Control group for the bit-serial CRC unit.
    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } t_crc_ctrl;

endpackage

// ===== rtl/crcdec_crc_unit.sv =====
// ----------------------------------------------------------------------------
// crcdec_crc_unit
// Bit-serial CRC-8 register: a byte is folded in on load, then one shift per
// cycle works the polynomial through it.
// ----------------------------------------------------------------------------
module crcdec_crc_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crcdec_pkg::t_crc_ctrl i_ctrl,
    input  logic [7:0]            i_data,
    output logic [7:0]            o_crc
);
    import crcdec_pkg::*;

    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [7:0] shifted;

    // One polynomial step on the top bit.
    assign shifted = r_crc[7] ? ({r_crc[6:0], 1'b0} ^ CRC_POLY) : {r_crc[6:0], 1'b0};

    always_comb begin
        n_crc = r_crc;
        if (i_ctrl.clear) begin
            n_crc = CRC_INIT;
        end else if (i_ctrl.load) begin
            n_crc = r_crc ^ i_data;
        end else if (i_ctrl.shift) begin
            n_crc = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// ===== rtl/card_record_crc_check_decode.sv =====
// Each of bytes 0..28, the last byte apart, loads the CRC and runs its shift
// phase before the next byte is taken; later bytes skip the CRC phase.
// On the last byte the results follow, each from a field store read and then
// an output register load (the status needs no read); an error gives one result.
// Reset is synchronous, active low; it clears the count, CRC, error, configuration
// registers, output valid and the sequencer. The field store and payload registers are not cleared.
// ----------------------------------------------------------------------------
// card_record_crc_check_decode
// Validates a card record byte stream with CRC-8 and header checks, then
// emits a status and, for a valid record, the decoded phone, student id and name fields.
// ----------------------------------------------------------------------------
module card_record_crc_check_decode #(
    parameter int RECORD_BYTES = crcdec_pkg::RECORD_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [crcdec_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    // Record byte input.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // [7:0] data_byte
    input  logic                             i_s_axis_tlast,  // end_of_record
    // Result output.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [15:0]                      o_m_axis_tdata,  // [15:0] value
    output logic [1:0]                       o_m_axis_tuser,  // [1:0] kind
    output logic                             o_m_axis_tlast   // final_res
);
    import crcdec_pkg::*;

    localparam int              PosW     = $clog2(RECORD_BYTES + 1);
    localparam logic [PosW-1:0] PosMax   = PosW'(RECORD_BYTES);
    localparam logic [PosW-1:0] PosCrc   = PosW'(CRC_POS);
    localparam logic [PosW-1:0] PosMin   = PosW'(MIN_BYTES);
    localparam logic [PosW-1:0] PosOne   = PosW'(1);

    // Registers.
    t_state            r_state;
    t_state            n_state;
    logic [PosW-1:0]   r_pos;
    logic [PosW-1:0]   n_pos;
    logic [1:0]        r_err;
    logic [1:0]        n_err;
    logic [7:0]        r_magic;
    logic [7:0]        r_version;
    logic [2:0]        r_bit_cnt;
    logic [2:0]        n_bit_cnt;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_status           r_status;
    t_status           n_status;
    logic [7:0]        r_lo;
    logic [7:0]        n_lo;
    logic [7:0]        r_rd;
    logic              r_out_valid;
    logic              n_out_valid;
    t_kind             r_out_kind;
    t_kind             n_out_kind;
    logic [15:0]       r_out_value;
    logic [15:0]       n_out_value;
    logic              r_out_last;
    logic              n_out_last;

    // Field store: entry i holds record byte i+1.
    logic [7:0]        mem [STORE_DEPTH];

    // Combinational signals.
    logic              in_xfer;
    logic              out_xfer;
    logic              can_load;
    logic [PosW-1:0]   pos_m1;
    logic [PosW-1:0]   count_next;
    logic [1:0]        err_next;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [STEP_W-1:0] step_p1;
    logic [STEP_W-1:0] step_m5;
    logic [3:0]        nibble;
    t_crc_ctrl         crc_ctrl;
    logic [7:0]        crc;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer        = r_out_valid && i_m_axis_tready;
    assign can_load        = !r_out_valid || i_m_axis_tready;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= 8'h00;
            r_version <= 8'h00;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MAGIC:   r_magic   <= i_cfg_data;
                REG_VERSION: r_version <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bit-serial CRC unit.
    crcdec_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .i_data  (i_s_axis_tdata),
        .o_crc   (crc)
    );

    // Byte position bookkeeping and header checks for the accepted byte.
    always_comb begin
        pos_m1     = r_pos - PosOne;
        count_next = (r_pos == PosMax) ? r_pos : (r_pos + PosOne);
        err_next   = r_err;
        if (r_err == 2'(ST_OK)) begin
            if (r_pos == '0 && i_s_axis_tdata != r_magic) begin
                err_next = 2'(ST_MAGIC);
            end else if (r_pos == PosOne && i_s_axis_tdata != r_version) begin
                err_next = 2'(ST_VERSION);
            end else if (r_pos == PosCrc && i_s_axis_tdata != crc) begin
                err_next = 2'(ST_CRC);
            end
        end
        wr_en   = in_xfer && (r_pos >= PosOne) && (r_pos < PosCrc);
        wr_addr = pos_m1[ADDR_W-1:0];
    end

    // Field store read address for the current emit step.
    always_comb begin
        step_p1 = r_step + STEP_W'(1);
        step_m5 = r_step - NAME_OFFSET;
        if (r_step <= STEP_DIGIT_L) begin
            rd_addr = step_p1[ADDR_W:1];
        end else if (r_step == STEP_ID_LO) begin
            rd_addr = ADDR_W'(6);
        end else if (r_step == STEP_ID_HI) begin
            rd_addr = ADDR_W'(7);
        end else begin
            rd_addr = step_m5[ADDR_W-1:0];
        end
        rd_en  = (r_state == S_READ);
        nibble = r_step[0] ? r_rd[7:4] : r_rd[3:0];
    end

    // Field store write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Sequencer: next state, CRC control and output register loads.
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_err       = r_err;
        n_bit_cnt   = r_bit_cnt;
        n_step      = r_step;
        n_status    = r_status;
        n_lo        = r_lo;
        n_out_valid = out_xfer ? 1'b0 : r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        crc_ctrl    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_s_axis_tlast) begin
                        // Record ends: settle the status and clear for the next one.
                        n_status = (count_next < PosMin) ? ST_SHORT
                                                         : t_status'({1'b0, err_next});
                        n_pos          = '0;
                        n_err          = '0;
                        crc_ctrl.clear = 1'b1;
                        n_step         = STEP_STATUS;
                        n_state        = S_WRITE;
                    end else begin
                        n_pos = count_next;
                        n_err = err_next;
                        if (r_pos < PosCrc) begin
                            crc_ctrl.load = 1'b1;
                            n_bit_cnt     = '0;
                            n_state       = S_CRC;
                        end
                    end
                end
            end

            S_CRC: begin
                crc_ctrl.shift = 1'b1;
                n_bit_cnt      = r_bit_cnt + 3'd1;
                if (r_bit_cnt == 3'd7) begin
                    n_state = S_IDLE;
                end
            end

            S_READ: begin
                n_state = S_WRITE;
            end

            S_WRITE: begin
                if (r_step == STEP_ID_LO) begin
                    // Low id byte is only held until the high byte is read.
                    n_lo    = r_rd;
                    n_step  = step_p1;
                    n_state = S_READ;
                end else if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b0;
                    if (r_step == STEP_STATUS) begin
                        n_out_kind  = KIND_STATUS;
                        n_out_value = {13'd0, r_status};
                        n_out_last  = (r_status != ST_OK);
                    end else if (r_step <= STEP_DIGIT_L) begin
                        n_out_kind  = KIND_DIGIT;
                        n_out_value = {8'd0, ASCII_ZERO + {4'd0, nibble}};
                    end else if (r_step == STEP_ID_HI) begin
                        n_out_kind  = KIND_ID;
                        n_out_value = {r_rd, r_lo};
                    end else begin
                        n_out_kind  = KIND_NAME;
                        n_out_value = {8'd0, r_rd};
                        n_out_last  = (r_step == STEP_LAST);
                    end
                    if ((r_step == STEP_STATUS && r_status != ST_OK) ||
                        r_step == STEP_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step  = step_p1;
                        n_state = S_READ;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_err       <= '0;
            r_bit_cnt   <= '0;
            r_step      <= STEP_STATUS;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_err       <= n_err;
            r_bit_cnt   <= n_bit_cnt;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_lo        <= n_lo;
        r_out_kind  <= n_out_kind;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    // The byte count never passes its saturation point.
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PosMax)
        else $error("byte position above saturation");

    // The CRC shift phase returns to idle after the shift at the top bit count.
    a_crc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRC && r_bit_cnt == 3'd7) |=> (r_state == S_IDLE))
        else $error("CRC shift phase did not end after eight steps");

    // An error status is always the only result of its record.
    a_err_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_STATUS && r_out_value != 16'd0)
        |-> r_out_last)
        else $error("error status without final flag");

    // No byte is taken while results are being produced.
    a_no_accept_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_WRITE) |-> !o_s_axis_tready)
        else $error("input ready during emit");

endmodule
